[rtl/unsigned_restoring_divider_assert.svh]
// assertion macros used by the divider checker
`ifndef UNSIGNED_RESTORING_DIVIDER_ASSERT_SVH
`define UNSIGNED_RESTORING_DIVIDER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define URD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("divider assertion failed");

// antecedent implies consequent in the next cycle
`define URD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("divider assertion failed");

`endif

[rtl/urd_pkg.sv]
// shared constants and types of the restoring divider
`default_nettype none

package urd_pkg;

   // operand width used by the arithmetic, 2 to 64
   localparam int DATA_WIDTH  = 64;
   // width of the port fields
   localparam int FIELD_WIDTH = 64;
   // step counter width
   localparam int CNT_WIDTH   = $clog2(DATA_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_WAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic load_zero;
      logic step;
      logic to_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic divisor_zero;
      logic last;
   } status_type;

endpackage

`default_nettype wire

[rtl/unsigned_restoring_divider.sv]
// unsigned radix-2 restoring divider, top level
//
// usage:
//   req channel (req_valid/req_ready) takes dividend and divisor, one
//   transaction at a time; rsp channel (rsp_valid/rsp_ready) returns
//   quotient, remainder and divide_by_zero, one transaction per request.
//   a zero divisor gives an all-ones quotient, zero remainder and the flag.
// operation:
//   the shared subtractor produces one quotient bit per cycle, so a nonzero
//   divisor takes DATA_WIDTH steps (64), after which the result moves to the
//   output register once it is free and rsp_valid rises; a zero divisor skips
//   the steps and goes straight to that move.
//   a new request is taken the cycle after the result moves out, so a new
//   transaction is not accepted until the previous one has moved out.
// reset:
//   synchronous, active high; clears the state machine and rsp_valid.
// stall:
//   a result held by rsp_ready low stays in the output register while the
//   next division runs; that division then waits until the register frees.
`default_nettype none

module unsigned_restoring_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [urd_pkg::FIELD_WIDTH-1:0] req_dividend,
   input  wire logic [urd_pkg::FIELD_WIDTH-1:0] req_divisor,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [urd_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   output logic      [urd_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   output logic                                 rsp_divide_by_zero
);

   urd_pkg::cmd_type    cmd;
   urd_pkg::status_type status;

   urd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   urd_datapath u_datapath (
      .clock              (clock),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .cmd                (cmd),
      .status             (status),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

`default_nettype wire

[rtl/urd_datapath.sv]
// operand, partial remainder, quotient and output registers of the divider
`default_nettype none

module urd_datapath (
   input  wire logic                              clock,
   input  wire logic [urd_pkg::FIELD_WIDTH-1:0]   req_dividend,
   input  wire logic [urd_pkg::FIELD_WIDTH-1:0]   req_divisor,
   input  wire urd_pkg::cmd_type                  cmd,
   output urd_pkg::status_type                    status,
   output logic      [urd_pkg::FIELD_WIDTH-1:0]   rsp_quotient,
   output logic      [urd_pkg::FIELD_WIDTH-1:0]   rsp_remainder,
   output logic                                   rsp_divide_by_zero
);

   localparam int DW = urd_pkg::DATA_WIDTH;

   logic [DW-1:0]                 num_ff, num_in;
   logic [DW-1:0]                 den_ff, den_in;
   logic [DW-1:0]                 part_ff, part_in;
   logic [DW-1:0]                 quo_ff, quo_in;
   logic                          dbz_ff, dbz_in;
   logic [urd_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]                 out_quo_ff, out_rem_ff;
   logic                          out_dbz_ff;

   logic [DW:0] shifted;
   logic [DW:0] diff;
   logic        fits;

   // one restoring step: shift in the next dividend bit, trial subtract
   assign shifted = {part_ff, num_ff[DW-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = ~diff[DW];

   // next values of the working registers
   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      part_in = part_ff;
      quo_in  = quo_ff;
      dbz_in  = dbz_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         num_in  = req_dividend[DW-1:0];
         den_in  = req_divisor[DW-1:0];
         part_in = '0;
         quo_in  = '0;
         dbz_in  = 1'b0;
         cnt_in  = '0;
      end else if (cmd.load_zero) begin
         part_in = '0;
         quo_in  = '1;
         dbz_in  = 1'b1;
      end else if (cmd.step) begin
         num_in  = {num_ff[DW-2:0], 1'b0};
         part_in = fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in  = {quo_ff[DW-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      part_ff <= part_in;
      quo_ff  <= quo_in;
      dbz_ff  <= dbz_in;
      cnt_ff  <= cnt_in;
   end

   // output register, loaded when the result moves out
   always_ff @(posedge clock) begin
      if (cmd.to_out) begin
         out_quo_ff <= quo_ff;
         out_rem_ff <= part_ff;
         out_dbz_ff <= dbz_ff;
      end
   end

   // status toward the controller
   assign status.divisor_zero = (req_divisor[DW-1:0] == '0);
   assign status.last         = (cnt_ff == urd_pkg::CNT_LAST);

   assign rsp_quotient       = urd_pkg::FIELD_WIDTH'(out_quo_ff);
   assign rsp_remainder      = urd_pkg::FIELD_WIDTH'(out_rem_ff);
   assign rsp_divide_by_zero = out_dbz_ff;

endmodule

`default_nettype wire

[rtl/urd_ctrl.sv]
// sequencing state machine of the divider
`default_nettype none

module urd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire urd_pkg::status_type status,
   output urd_pkg::cmd_type         cmd
);

   urd_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= urd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         urd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.divisor_zero) begin
                  cmd.load_zero = 1'b1;
                  state_in      = urd_pkg::ST_WAIT;
               end else begin
                  cmd.load = 1'b1;
                  state_in = urd_pkg::ST_BUSY;
               end
            end
         end
         urd_pkg::ST_BUSY: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = urd_pkg::ST_WAIT;
            end
         end
         urd_pkg::ST_WAIT: begin
            // move result out once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.to_out = 1'b1;
               state_in   = urd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = urd_pkg::ST_IDLE;
         end
      endcase
   end

   // output valid holds until the transaction completes
   assign rsp_valid_in = cmd.to_out | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/urd_checker.sv]
// port-level checker of the divider and its bind
`default_nettype none

`include "unsigned_restoring_divider_assert.svh"

module urd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic [urd_pkg::FIELD_WIDTH-1:0] req_dividend,
   input wire logic [urd_pkg::FIELD_WIDTH-1:0] req_divisor,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [urd_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   input wire logic [urd_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   input wire logic                            rsp_divide_by_zero
);

   localparam logic [urd_pkg::FIELD_WIDTH-1:0] ALL_ONES =
      urd_pkg::FIELD_WIDTH'({urd_pkg::DATA_WIDTH{1'b1}});

   logic req_taken;
   logic nonzero_taken;

   assign req_taken     = req_valid & req_ready;
   assign nonzero_taken = req_taken & (req_divisor[urd_pkg::DATA_WIDTH-1:0] != '0);

   // stalled response keeps valid
   `URD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // stalled response keeps its payload
   `URD_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
      $stable(rsp_quotient) && $stable(rsp_remainder) && $stable(rsp_divide_by_zero))
   // zero divisor result carries the fixed values
   `URD_ASSERT_SAME(a_dbz_values, rsp_valid && rsp_divide_by_zero,
      rsp_quotient == ALL_ONES && rsp_remainder == '0)
   // an accepted real division closes the request side
   `URD_ASSERT_NEXT(a_busy_after_accept, nonzero_taken, !req_ready)

endmodule

bind unsigned_restoring_divider urd_checker u_checker (.*);

`default_nettype wire
